@@ rtl/mdag_pkg.sv @@
// shared types and constants for the multidimensional array address generator
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package mdag_pkg;

    localparam int ADDR_W = 32;
    localparam int SIZE_W = 16;
    localparam int DIMS_W = 5;
    localparam int ID_W   = 4;
    localparam int DIM_W  = 4;
    localparam int FUNC_W = 2;

    localparam int MAX_DIMS_DEF   = 16;
    localparam int NUM_ARRAYS_DEF = 16;

    // function codes of an input word
    localparam logic [FUNC_W-1:0] FUNC_HEADER = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_BOUNDS = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_SUBSCR = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_ACC,
        ST_SCALE,
        ST_SUM
    } state_t;

    typedef struct packed {
        logic [ADDR_W-1:0] base;
        logic [SIZE_W-1:0] size;
        logic [DIMS_W-1:0] dims;
    } desc_t;

    typedef struct packed {
        logic [ADDR_W-1:0] low;
        logic [ADDR_W-1:0] extent;
    } bounds_t;

endpackage

`default_nettype wire

@@ rtl/mdag_if.sv @@
// valid/ready channel interfaces for the input and result words
// depends on mdag_pkg
`timescale 1ns / 1ps
`default_nettype none

interface mdag_in_if;
    logic                             valid;
    logic                             ready;
    logic [mdag_pkg::FUNC_W-1:0]      func;
    logic [mdag_pkg::ID_W-1:0]        array_id;
    logic [mdag_pkg::DIM_W-1:0]       dim_index;
    logic [mdag_pkg::ADDR_W-1:0]      base_addr;
    logic [mdag_pkg::SIZE_W-1:0]      elem_size;
    logic [mdag_pkg::DIMS_W-1:0]      num_dims;
    logic signed [mdag_pkg::ADDR_W-1:0] lower_bound;
    logic signed [mdag_pkg::ADDR_W-1:0] upper_bound;
    logic signed [mdag_pkg::ADDR_W-1:0] subscript;

    modport source (
        output valid, func, array_id, dim_index, base_addr, elem_size, num_dims,
               lower_bound, upper_bound, subscript,
        input  ready
    );
    modport sink (
        input  valid, func, array_id, dim_index, base_addr, elem_size, num_dims,
               lower_bound, upper_bound, subscript,
        output ready
    );
endinterface

interface mdag_out_if;
    logic                        valid;
    logic                        ready;
    logic [mdag_pkg::ADDR_W-1:0] address;

    modport source (output valid, address, input ready);
    modport sink (input valid, address, output ready);
endinterface

`default_nettype wire

@@ rtl/mdag_ram.sv @@
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module mdag_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                                    clk,
    input  wire logic                                    wr_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                        wr_data,
    input  wire logic                                    rd_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                        rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/multidim_array_address_generator.sv @@
// row-major address generator: descriptor tables plus a shared multiply/add unit
// depends on mdag_pkg, mdag_if and mdag_ram
//
// usage
// in_ch carries header words (base, element size, dimension count), bounds
// words (lower and upper bound of one dimension) and subscript words, one
// dimension at a time starting at dimension 0. out_ch returns one address
// after the last dimension of a query: base + offset * element size, mod 2^32.
// header and bounds words are written straight into the tables. a
// subscript word occupies the block for a table read, a subtract and
// multiply, and an accumulate; the last subscript of a query adds the
// scaling multiply and the base add before the address appears. a single
// multiplier and a single adder are reused in each step; the table read
// forms the first step. in_ch.ready is high only while the sequencer is idle.
// the result sits in an output register; a stalled receiver holds it while
// the next word is taken, and a second result waits in the final step.
// reset clears the sequencer, the running offset and the output valid; the
// descriptor tables hold nothing defined until written.
`timescale 1ns / 1ps
`default_nettype none

module multidim_array_address_generator #(
    parameter int MAX_DIMS   = mdag_pkg::MAX_DIMS_DEF,
    parameter int NUM_ARRAYS = mdag_pkg::NUM_ARRAYS_DEF
) (
    input wire logic   clk,
    input wire logic   rst_n,
    mdag_in_if.sink    in_ch,
    mdag_out_if.source out_ch
);

    import mdag_pkg::*;

    localparam int DESC_AW   = (NUM_ARRAYS > 1) ? $clog2(NUM_ARRAYS) : 1;
    localparam int DIM_DEPTH = NUM_ARRAYS * MAX_DIMS;
    localparam int DIM_AW    = (DIM_DEPTH > 1) ? $clog2(DIM_DEPTH) : 1;
    localparam int SLOT_W    = 13;

    state_t            state_reg, state_next;
    logic [ADDR_W-1:0] sub_reg, sub_next;
    logic [DIM_W-1:0]  dim_reg, dim_next;
    logic [ADDR_W-1:0] diff_reg, diff_next;
    logic [ADDR_W-1:0] prod_reg, prod_next;
    logic [ADDR_W-1:0] offset_reg, offset_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic              out_valid_reg, out_valid_next;

    logic              accept;
    logic              id_ok;
    logic              dim_ok;
    logic [DESC_AW+ID_W-1:0] id_ext;
    logic [SLOT_W-1:0] slot_wide;
    logic [DIMS_W-1:0] dims_sat;

    logic              desc_we;
    logic              dim_we;
    logic              rd_en;
    desc_t             desc_wdata, desc_rdata;
    bounds_t           bnd_wdata, bnd_rdata;

    logic [ADDR_W-1:0] mul_a, mul_b, mul_res;
    logic [ADDR_W-1:0] add_a, add_b, add_res;
    logic              add_cin;
    logic              last_dim;
    logic              load_out;

    assign accept    = in_ch.valid && in_ch.ready;
    assign id_ok     = {{(9-ID_W){1'b0}}, in_ch.array_id} < 9'(NUM_ARRAYS);
    assign dim_ok    = {1'b0, in_ch.dim_index} < 5'(MAX_DIMS);
    assign id_ext    = (DESC_AW+ID_W)'(in_ch.array_id);
    assign slot_wide = SLOT_W'(in_ch.array_id) * SLOT_W'(MAX_DIMS) + SLOT_W'(in_ch.dim_index);

    // dimension count saturates into 1 .. MAX_DIMS
    always_comb
    begin
        dims_sat = in_ch.num_dims;
        if (in_ch.num_dims == '0)
        begin
            dims_sat = DIMS_W'(1);
        end
        else if (in_ch.num_dims > DIMS_W'(MAX_DIMS))
        begin
            dims_sat = DIMS_W'(MAX_DIMS);
        end
    end

    assign desc_wdata.base  = in_ch.base_addr;
    assign desc_wdata.size  = in_ch.elem_size;
    assign desc_wdata.dims  = dims_sat;
    assign bnd_wdata.low    = in_ch.lower_bound;
    assign bnd_wdata.extent = in_ch.upper_bound - in_ch.lower_bound + ADDR_W'(1);

    always_comb
    begin
        desc_we = 1'b0;
        dim_we  = 1'b0;
        rd_en   = 1'b0;
        if (accept && id_ok)
        begin
            unique case (in_ch.func)
                FUNC_HEADER: desc_we = 1'b1;
                FUNC_BOUNDS: dim_we  = dim_ok;
                FUNC_SUBSCR: rd_en   = dim_ok;
                default:     ;
            endcase
        end
    end

    mdag_ram #(
        .WIDTH ($bits(desc_t)),
        .DEPTH (NUM_ARRAYS)
    ) u_desc_ram (
        .clk     (clk),
        .wr_en   (desc_we),
        .wr_addr (id_ext[DESC_AW-1:0]),
        .wr_data (desc_wdata),
        .rd_en   (rd_en),
        .rd_addr (id_ext[DESC_AW-1:0]),
        .rd_data (desc_rdata)
    );

    mdag_ram #(
        .WIDTH ($bits(bounds_t)),
        .DEPTH (DIM_DEPTH)
    ) u_dim_ram (
        .clk     (clk),
        .wr_en   (dim_we),
        .wr_addr (slot_wide[DIM_AW-1:0]),
        .wr_data (bnd_wdata),
        .rd_en   (rd_en),
        .rd_addr (slot_wide[DIM_AW-1:0]),
        .rd_data (bnd_rdata)
    );

    // shared arithmetic
    assign mul_res = ADDR_W'(mul_a * mul_b);
    assign add_res = add_a + add_b + ADDR_W'(add_cin);

    assign last_dim = ({1'b0, dim_reg} + DIMS_W'(1)) == desc_rdata.dims;
    assign load_out = (state_reg == ST_SUM) && (!out_valid_reg || out_ch.ready);

    always_comb
    begin
        state_next  = state_reg;
        sub_next    = sub_reg;
        dim_next    = dim_reg;
        diff_next   = diff_reg;
        prod_next   = prod_reg;
        offset_next = offset_reg;
        addr_next   = addr_reg;
        mul_a       = offset_reg;
        mul_b       = bnd_rdata.extent;
        add_a       = sub_reg;
        add_b       = ~bnd_rdata.low;
        add_cin     = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (rd_en)
                begin
                    sub_next   = in_ch.subscript;
                    dim_next   = in_ch.dim_index;
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                // subscript minus lower bound, and running offset times extent
                add_cin = 1'b1;
                if ({1'b0, dim_reg} >= desc_rdata.dims)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    diff_next  = add_res;
                    prod_next  = mul_res;
                    state_next = ST_ACC;
                end
            end
            ST_ACC:
            begin
                // dimension 0 restarts the offset
                add_a       = (dim_reg == '0) ? '0 : prod_reg;
                add_b       = diff_reg;
                offset_next = add_res;
                state_next  = last_dim ? ST_SCALE : ST_IDLE;
            end
            ST_SCALE:
            begin
                mul_b      = {{(ADDR_W-SIZE_W){1'b0}}, desc_rdata.size};
                prod_next  = mul_res;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                add_a = desc_rdata.base;
                add_b = prod_reg;
                if (load_out)
                begin
                    addr_next  = add_res;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid_next = load_out || (out_valid_reg && !out_ch.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            offset_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            offset_reg    <= offset_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sub_reg  <= sub_next;
        dim_reg  <= dim_next;
        diff_reg <= diff_next;
        prod_reg <= prod_next;
        addr_reg <= addr_next;
    end

    assign in_ch.ready    = (state_reg == ST_IDLE);
    assign out_ch.valid   = out_valid_reg;
    assign out_ch.address = addr_reg;

endmodule

`default_nettype wire
